// File: hw/rtl/eucl_pkg.sv
package eucl_pkg;

	localparam int DIM_W = 7;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_FINAL,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;        // register |first - second|
		logic square;      // register the square of the held magnitude
		logic root_start;  // take the final sum into the root unit, clear the sum
		logic root_step;   // one result bit of the square root
		logic publish;     // move the root into the output register
	} cmd_t;

endpackage

// File: hw/rtl/eucl_dp.sv
module eucl_dp import eucl_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int SUM_W = 38,
	parameter int ROOT_W = 19
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  logic [COORD_WIDTH-1:0] coord_first,
	input  logic [COORD_WIDTH-1:0] coord_second,
	output logic [ROOT_W-1:0]      distance
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic [COORD_WIDTH:0]     diff;
	logic [COORD_WIDTH:0]     diff_neg;
	logic [COORD_WIDTH-1:0]   mag_s1;
	logic [2*COORD_WIDTH-1:0] sq_s2;
	logic                     sq_vld_s2;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         acc_sum;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W:0]    trial;
	logic [ROOT_W-1:0] dist_q;

	assign diff = {coord_first[COORD_WIDTH-1], coord_first}
		- {coord_second[COORD_WIDTH-1], coord_second};
	assign diff_neg = -diff;

	// the pending square joins the sum in the cycle after it is formed
	assign acc_sum = sq_vld_s2 ? (sum_q + SUM_W'(sq_s2)) : sum_q;

	// bring down the next two radicand bits and try root*4 + 1
	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, rem_sh} - {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s2 <= 1'b0;
			sum_q     <= '0;
		end else begin
			sq_vld_s2 <= cmd.square;
			if (cmd.root_start) begin
				sum_q <= '0;
			end else begin
				sum_q <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_s1 <= diff[COORD_WIDTH] ? diff_neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];
		end
		if (cmd.square) begin
			sq_s2 <= mag_s1 * mag_s1;
		end
		if (cmd.root_start) begin
			rad_q  <= RAD_W'(acc_sum);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (!trial[REM_W]) begin
				rem_q  <= trial[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.publish) begin
			dist_q <= root_q;
		end
	end

	assign distance = dist_q;

endmodule

// File: hw/rtl/eucl_ctrl.sv
module eucl_ctrl import eucl_pkg::*; #(
	parameter int MAX_DIMENSION = 64,
	parameter int ROOT_W = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_data,
	output cmd_t             cmd
);

	localparam int CNT_W  = $clog2(MAX_DIMENSION + 1);
	localparam int CMP_W  = (CNT_W > DIM_W) ? CNT_W : DIM_W;
	localparam int ITER_W = $clog2(ROOT_W);

	state_t            state_q, state_d;
	logic [DIM_W-1:0]  dim_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic              out_valid_q, out_valid_d;
	logic [CMP_W-1:0]  dim_ext;
	logic [CMP_W-1:0]  eff_dim;
	logic [CMP_W-1:0]  cnt_inc;

	// zero counts as one, anything above the maximum saturates
	assign dim_ext = CMP_W'(dim_q);
	always_comb begin
		if (dim_ext == '0) begin
			eff_dim = CMP_W'(1);
		end else if (dim_ext > CMP_W'(MAX_DIMENSION)) begin
			eff_dim = CMP_W'(MAX_DIMENSION);
		end else begin
			eff_dim = dim_ext;
		end
	end

	assign cnt_inc = CMP_W'(count_q) + CMP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_q       <= DIM_RESET;
			count_q     <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			iter_q      <= iter_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				dim_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		iter_d   = iter_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				if (cnt_inc >= eff_dim) begin
					count_d = '0;
					state_d = ST_FINAL;
				end else begin
					count_d = count_q + CNT_W'(1);
					state_d = ST_IDLE;
				end
			end
			ST_FINAL: begin
				cmd.root_start = 1'b1;
				iter_d         = ITER_W'(ROOT_W - 1);
				state_d        = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (iter_q == '0) begin
					state_d = ST_DONE;
				end else begin
					iter_d = iter_q - ITER_W'(1);
				end
			end
			ST_DONE: begin
				// hold the root until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.publish) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/euclidean_distance_top.sv
// Euclidean distance between two points, streamed one coordinate at a time.
// Input stream (s_*): each item carries the same coordinate of both points,
// signed fixed point with 8 fraction bits. After as many items as the
// dimension register asks for (zero counts as one, values above MAX_DIMENSION
// saturate), one item leaves on the output stream (m_*): the floor of the
// square root of the summed squared differences, 8 fraction bits.
// Each coordinate is accepted, then squared, before the next one is taken.
// After the last coordinate of a vector, the sum goes to the bit-serial square
// root, one result bit a cycle, through ST_FINAL, ST_ROOT and ST_DONE into the
// output register that drives m_tvalid.
// The output register frees the input side: a new vector is taken while the
// previous distance waits. If the receiver stalls, a second finished root
// waits in the block and s_tready stays low until the output register frees.
// Write the dimension through cfg_we / cfg_data only while the block is idle.
// Reset clears the sum and the count, sets the dimension to 2 and drops
// m_tvalid.
module euclidean_distance_top import eucl_pkg::*; #(
	parameter int MAX_DIMENSION = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [COORD_WIDTH-1:0] coord_first, [2*COORD_WIDTH-1:COORD_WIDTH] coord_second
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [ROOT_W-1:0] distance, zero above
	output logic [(((((2*COORD_WIDTH+$clog2(MAX_DIMENSION))+1)/2)+7)/8)*8-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [DIM_W-1:0]       cfg_data
);

	localparam int SUM_W       = 2 * COORD_WIDTH + $clog2(MAX_DIMENSION);
	localparam int ROOT_W      = (SUM_W + 1) / 2;
	localparam int OUT_TDATA_W = ((ROOT_W + 7) / 8) * 8;

	cmd_t              cmd;
	logic [ROOT_W-1:0] distance;

	eucl_ctrl #(
		.MAX_DIMENSION(MAX_DIMENSION),
		.ROOT_W       (ROOT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd)
	);

	eucl_dp #(
		.COORD_WIDTH(COORD_WIDTH),
		.SUM_W      (SUM_W),
		.ROOT_W     (ROOT_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.coord_first (s_tdata[COORD_WIDTH-1:0]),
		.coord_second(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.distance    (distance)
	);

	assign m_tdata = OUT_TDATA_W'(distance);

endmodule
